[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion helper macros
// Immediate-implication and next-cycle-implication property checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[hdl/bcs_pkg.sv]
// ---------------------------------------------------------------------------
// bcs_pkg
// Shared types and constants of the Bezier curve sampler.
// ---------------------------------------------------------------------------
package bcs_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_W        = 24;
  localparam int U_W            = 17;
  localparam int PT_W           = 3 * COORD_W;
  localparam int LANES          = 3;

  localparam logic [U_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [U_W-1:0] MIN_STEP   = 17'd1058;
  localparam logic [U_W-1:0] RESET_STEP = 17'd6554;

  // pipeline depth after the last read of a pass, minus one
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic pt_we;    // store incoming control point
    logic rd_en;    // read one working entry
    logic src_pts;  // read from the point store (first pass)
    logic lerp;     // this read closes an interpolation pair
    logic fin;      // single-output pass: result is the curve sample
  } cmd_t;

endpackage

[hdl/bcs_ram.sv]
// ---------------------------------------------------------------------------
// bcs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bcs_ctrl.sv]
// ---------------------------------------------------------------------------
// bcs_ctrl
// Sequencer: point loading, de Casteljau pass scheduling, sample stepping.
// ---------------------------------------------------------------------------
module bcs_ctrl #(
  parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
  localparam int AW        = $clog2(MAX_POINTS),
  localparam int CW        = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [bcs_pkg::U_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_set_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [bcs_pkg::U_W-1:0] out_curve_u,
  output logic                    out_run_end,
  output bcs_pkg::cmd_t           cmd,
  output logic [AW-1:0]           rd_addr,
  output logic [AW-1:0]           wr_addr,
  output logic [AW-1:0]           pt_waddr,
  output logic [bcs_pkg::U_W-1:0] u_val
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic [CW-1:0] TWO     = CW'(2);

  bcs_pkg::state_t          state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic [CW-1:0]            m_r, m_nxt;
  logic [AW-1:0]            j_r, j_nxt;
  logic                     first_r, first_nxt;
  logic                     last_r, last_nxt;
  logic [1:0]               drain_r, drain_nxt;
  logic [bcs_pkg::U_W-1:0]  u_r, u_nxt;
  logic [bcs_pkg::U_W-1:0]  step_r;
  logic [bcs_pkg::U_W-1:0]  step_eff;
  logic [bcs_pkg::U_W:0]    u_sum;
  logic [CW-1:0]            n_new;
  logic [CW-1:0]            m_dec;

  assign step_eff = (step_r < bcs_pkg::MIN_STEP) ? bcs_pkg::MIN_STEP : step_r;
  assign u_sum    = {1'b0, u_r} + {1'b0, step_eff};
  assign n_new    = (cnt_r < MAX_CNT) ? cnt_r + CW'(1) : cnt_r;
  assign m_dec    = m_r - CW'(1);

  assign rd_addr     = j_r;
  assign wr_addr     = j_r - AW'(1);
  assign pt_waddr    = cnt_r[AW-1:0];
  assign u_val       = u_r;
  assign out_curve_u = u_r;
  assign out_run_end = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcs_pkg::S_LOAD;
      cnt_r   <= '0;
      n_r     <= '0;
      m_r     <= '0;
      j_r     <= '0;
      first_r <= 1'b0;
      last_r  <= 1'b0;
      drain_r <= '0;
      u_r     <= '0;
      step_r  <= bcs_pkg::RESET_STEP;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      j_r     <= j_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      drain_r <= drain_nxt;
      u_r     <= u_nxt;
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    j_nxt     = j_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    drain_nxt = drain_r;
    u_nxt     = u_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      bcs_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // drop points once the store is full
          if (cnt_r < MAX_CNT) begin
            cmd.pt_we = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
          end
          if (in_set_end) begin
            cnt_nxt = '0;
            if (n_new >= TWO) begin
              n_nxt     = n_new;
              m_nxt     = n_new;
              j_nxt     = '0;
              first_nxt = 1'b1;
              last_nxt  = 1'b0;
              u_nxt     = '0;
              state_nxt = bcs_pkg::S_RUN;
            end
          end
        end
      end
      bcs_pkg::S_RUN: begin
        cmd.rd_en   = 1'b1;
        cmd.src_pts = first_r;
        cmd.lerp    = (j_r != '0);
        cmd.fin     = (m_r == TWO);
        if (j_r == m_dec[AW-1:0]) begin
          drain_nxt = '0;
          state_nxt = bcs_pkg::S_DRAIN;
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      bcs_pkg::S_DRAIN: begin
        // hold until the last write of this pass has landed
        if (drain_r == bcs_pkg::DRAIN_LAST) begin
          if (m_r == TWO) begin
            state_nxt = bcs_pkg::S_EMIT;
          end else begin
            m_nxt     = m_dec;
            j_nxt     = '0;
            first_nxt = 1'b0;
            state_nxt = bcs_pkg::S_RUN;
          end
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      bcs_pkg::S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_r) begin
            state_nxt = bcs_pkg::S_LOAD;
          end else begin
            // past 1.0: close with the sample at exactly 1.0
            if (u_sum > {1'b0, bcs_pkg::ONE_Q16}) begin
              u_nxt    = bcs_pkg::ONE_Q16;
              last_nxt = 1'b1;
            end else begin
              u_nxt = u_sum[bcs_pkg::U_W-1:0];
            end
            m_nxt     = n_r;
            j_nxt     = '0;
            first_nxt = 1'b1;
            state_nxt = bcs_pkg::S_RUN;
          end
        end
      end
      default: begin
        state_nxt = bcs_pkg::S_LOAD;
      end
    endcase
  end

endmodule

[hdl/bcs_dp.sv]
// ---------------------------------------------------------------------------
// bcs_dp
// Point store, working store and the three-lane interpolation pipeline.
// ---------------------------------------------------------------------------
module bcs_dp #(
  parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
  localparam int AW        = $clog2(MAX_POINTS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bcs_pkg::cmd_t               cmd,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [AW-1:0]               pt_waddr,
  input  logic [bcs_pkg::U_W-1:0]     u_val,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_x,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_y,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_z,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_x,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_y,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_z
);

  localparam int CWD = bcs_pkg::COORD_W;
  localparam int DW  = CWD + 1;
  localparam int PW  = DW + bcs_pkg::U_W + 1;
  localparam int SW  = PW - 16;

  logic [bcs_pkg::PT_W-1:0] pt_q, wk_q, wk_wdata;

  // stage 1: read data returns
  logic          rd1_r, src1_r, lv1_r, fin1_r;
  logic [AW-1:0] wa1_r;
  bcs_pkg::coord_t cur   [bcs_pkg::LANES];
  bcs_pkg::coord_t prev_r[bcs_pkg::LANES];

  // stage 2: difference registered
  logic          lv2_r, fin2_r;
  logic [AW-1:0] wa2_r;
  bcs_pkg::coord_t   a2_r   [bcs_pkg::LANES];
  logic signed [DW-1:0] diff2_r[bcs_pkg::LANES];

  // stage 3: product registered
  logic          lv3_r, fin3_r;
  logic [AW-1:0] wa3_r;
  bcs_pkg::coord_t   a3_r   [bcs_pkg::LANES];
  logic signed [PW-1:0] prod3_r[bcs_pkg::LANES];

  logic signed [SW-1:0] sum [bcs_pkg::LANES];
  bcs_pkg::coord_t      res [bcs_pkg::LANES];

  bcs_ram #(.WIDTH(bcs_pkg::PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (cmd.pt_we),
    .waddr (pt_waddr),
    .wdata ({in_ctrl_x, in_ctrl_y, in_ctrl_z}),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (pt_q)
  );

  bcs_ram #(.WIDTH(bcs_pkg::PT_W), .DEPTH(MAX_POINTS)) u_wk_ram (
    .clk   (clk),
    .we    (lv3_r),
    .waddr (wa3_r),
    .wdata (wk_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (wk_q)
  );

  always_comb begin
    for (int k = 0; k < bcs_pkg::LANES; k++) begin
      cur[k] = src1_r ? pt_q[bcs_pkg::PT_W-1-k*CWD -: CWD]
                      : wk_q[bcs_pkg::PT_W-1-k*CWD -: CWD];
      // a + floor(u*(b-a)/2^16)
      sum[k] = {{(SW-CWD){a3_r[k][CWD-1]}}, a3_r[k]} + prod3_r[k][PW-1:16];
      res[k] = sum[k][CWD-1:0];
    end
    wk_wdata = {res[0], res[1], res[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd1_r <= 1'b0;
      lv1_r <= 1'b0;
      lv2_r <= 1'b0;
      lv3_r <= 1'b0;
    end else begin
      rd1_r <= cmd.rd_en;
      lv1_r <= cmd.rd_en & cmd.lerp;
      lv2_r <= lv1_r;
      lv3_r <= lv2_r;
    end
  end

  always_ff @(posedge clk) begin
    src1_r <= cmd.src_pts;
    fin1_r <= cmd.fin;
    wa1_r  <= wr_addr;
    fin2_r <= fin1_r;
    wa2_r  <= wa1_r;
    fin3_r <= fin2_r;
    wa3_r  <= wa2_r;
    for (int k = 0; k < bcs_pkg::LANES; k++) begin
      if (rd1_r) begin
        prev_r[k] <= cur[k];
      end
      a2_r[k]    <= prev_r[k];
      diff2_r[k] <= {cur[k][CWD-1], cur[k]} - {prev_r[k][CWD-1], prev_r[k]};
      a3_r[k]    <= a2_r[k];
      prod3_r[k] <= PW'($signed({1'b0, u_val})) * PW'(diff2_r[k]);
    end
    if (lv3_r && fin3_r) begin
      out_curve_x <= res[0];
      out_curve_y <= res[1];
      out_curve_z <= res[2];
    end
  end

endmodule

[hdl/bezier_curve_sampler.sv]
// ---------------------------------------------------------------------------
// bezier_curve_sampler
// Samples a 3D Bezier curve from a loaded set of control points.
// ---------------------------------------------------------------------------
// Input requests carry one control point each (signed Q8.16); the request
// with in_set_end high closes the set. Points past MAX_POINTS are dropped.
// A closed set of n >= 2 points yields one output request per sample: u runs
// from 0 by cfg step (floored at 1058) while u <= 1.0, then a closing sample
// at u = 1.0 with out_run_end high. Smaller sets yield nothing.
// Loading accepts one point per cycle. Each sample runs n-1 interpolation
// passes through the working RAM, paced by its single read port; a pass of
// m entries reads each entry once and then drains the pipeline before the
// next pass starts. A finished sample shows until it is taken.
// in_ready is low from the closing point until the final sample is taken.
// A stalled out_ready holds the sample and freezes the sequencer.
// Reset (rst_n low, synchronous) empties the point set and sets the step
// to 6554; no memory clearing is needed. Write cfg_wdata only while idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bezier_curve_sampler #(
  parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bcs_pkg::U_W-1:0]     cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_x,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_y,
  input  logic [bcs_pkg::COORD_W-1:0] in_ctrl_z,
  input  logic                        in_set_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_x,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_y,
  output logic [bcs_pkg::COORD_W-1:0] out_curve_z,
  output logic [bcs_pkg::U_W-1:0]     out_curve_u,
  output logic                        out_run_end
);

  localparam int AW = $clog2(MAX_POINTS);

  bcs_pkg::cmd_t           cmd;
  logic [AW-1:0]           rd_addr, wr_addr, pt_waddr;
  logic [bcs_pkg::U_W-1:0] u_val;

  bcs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_set_end  (in_set_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_curve_u (out_curve_u),
    .out_run_end (out_run_end),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .pt_waddr    (pt_waddr),
    .u_val       (u_val)
  );

  bcs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .pt_waddr    (pt_waddr),
    .u_val       (u_val),
    .in_ctrl_x   (in_ctrl_x),
    .in_ctrl_y   (in_ctrl_y),
    .in_ctrl_z   (in_ctrl_z),
    .out_curve_x (out_curve_x),
    .out_curve_y (out_curve_y),
    .out_curve_z (out_curve_z)
  );

  // loading and emitting never overlap
  `CHK_NOW(a_no_overlap, clk, rst_n, 1'b1, !(in_ready && out_valid))
  // the closing sample sits at exactly 1.0
  `CHK_NOW(a_end_at_one, clk, rst_n, out_valid && out_run_end, out_curve_u == bcs_pkg::ONE_Q16)
  // taking the closing sample returns to loading
  `CHK_NEXT(a_end_to_load, clk, rst_n, out_valid && out_ready && out_run_end, in_ready)

endmodule
